>>> design/palr_pkg.sv
// ----------------------------------------------------------------------------
// palr_pkg: shared types and constants
// Widths, codes, state encodings and transaction structs for the polyline
// arc-length resampler.
// ----------------------------------------------------------------------------
package palr_pkg;

  localparam int COORD_W   = 28;
  localparam int PRES_W    = 16;
  localparam int IDX_W     = 16;
  localparam int SPACING_W = 20;
  localparam int MAXS_W    = 16;
  localparam int DIST_W    = 29;   // distance_left
  localparam int LEN_W     = 29;   // segment length and lerp quotient
  localparam int T_W       = 30;   // running sample position
  localparam int RAD_W     = 58;   // squared length, lerp numerator
  localparam int CNT_W     = $clog2(LEN_W);

  localparam int MAX_PER_POINT = 63;
  localparam int MADE_W        = $clog2(MAX_PER_POINT + 1);
  localparam int MAX_RESULTS   = MAX_PER_POINT + 1;
  localparam int BUF_AW        = $clog2(MAX_RESULTS);
  localparam int NRES_W        = $clog2(MAX_RESULTS + 1);

  localparam logic [SPACING_W-1:0] SPACING_RESET = 20'd1280;
  localparam logic [MAXS_W-1:0]    MAXS_RESET    = 16'd50000;
  localparam logic [PRES_W-1:0]    VAR_THRESHOLD = 16'd656;
  localparam logic [3:0]           TAIL_DIST2    = 4'd7;

  typedef enum logic [0:0] {
    REG_SPACING     = 1'b0,
    REG_MAX_SAMPLES = 1'b1
  } palr_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EVAL,
    ST_SQX,
    ST_SQY,
    ST_ROOT_GO,
    ST_ROOT_WAIT,
    ST_LOOP,
    ST_MUL,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_STORE,
    ST_END_SEG,
    ST_TAIL,
    ST_DRAIN_RD,
    ST_DRAIN_LD
  } palr_state_t;

  typedef enum logic [1:0] {
    COMP_X,
    COMP_Y,
    COMP_P
  } palr_comp_t;

  typedef enum logic [0:0] {
    OP_ROOT = 1'b0,
    OP_DIV  = 1'b1
  } palr_op_t;

  typedef struct packed {
    logic     start;
    palr_op_t op;
  } palr_unit_ctl_t;

  typedef struct packed {
    logic             done;
    logic [LEN_W-1:0] result;
  } palr_unit_sts_t;

  // one buffered result, flags are attached on the way out
  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [PRES_W-1:0]         p;
    logic [IDX_W-1:0]          idx;
    logic                      tail;
  } palr_entry_t;

endpackage

>>> design/palr_in_if.sv
// ----------------------------------------------------------------------------
// palr_in_if: input point channel
// Valid/ready channel carrying one stylus point per transaction.
// ----------------------------------------------------------------------------
interface palr_in_if;
  import palr_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] x_pos;
  logic signed [COORD_W-1:0] y_pos;
  logic [PRES_W-1:0]         pen_pressure;
  logic                      first_point;
  logic                      last_point;

  modport source (output valid, x_pos, y_pos, pen_pressure, first_point, last_point,
                  input ready);
  modport sink   (input valid, x_pos, y_pos, pen_pressure, first_point, last_point,
                  output ready);
endinterface

>>> design/palr_out_if.sv
// ----------------------------------------------------------------------------
// palr_out_if: sample output channel
// Valid/ready channel carrying one resampled point per transaction.
// ----------------------------------------------------------------------------
interface palr_out_if;
  import palr_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] sample_x;
  logic signed [COORD_W-1:0] sample_y;
  logic [PRES_W-1:0]         sample_pressure;
  logic [IDX_W-1:0]          sample_index;
  logic                      is_tail;
  logic                      capped;
  logic                      truncated;
  logic                      variable_pressure;
  logic                      run_end;

  modport source (output valid, sample_x, sample_y, sample_pressure, sample_index,
                  is_tail, capped, truncated, variable_pressure, run_end,
                  input ready);
  modport sink   (input valid, sample_x, sample_y, sample_pressure, sample_index,
                  is_tail, capped, truncated, variable_pressure, run_end,
                  output ready);
endinterface

>>> design/polyline_arc_length_resampler_unit.sv
// A first point goes straight to its sample; a later point first has its
//   segment length taken as a square root, then each sample takes three lerps,
//   each a multiply and a divide through the one shared unit.
// One point at a time; results drain from the 64-entry result buffer, held
//   while the receiver stalls, then the next point is taken.
// Reset (rst_n low, synchronous): registers at defaults, stroke state cleared.
// ----------------------------------------------------------------------------
// polyline_arc_length_resampler_unit: uniform arc-length stroke resampler
// Walks the polyline of incoming stylus points and emits evenly spaced,
// linearly interpolated samples, plus stroke start and tail points.
// ----------------------------------------------------------------------------
module polyline_arc_length_resampler_unit import palr_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  palr_in_if.sink      in_chan,
  palr_out_if.source   out_chan,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  palr_state_t state_r, state_nxt;

  // configuration
  logic [SPACING_W-1:0] spacing_r;
  logic [MAXS_W-1:0]    max_samp_r;

  // latched point
  logic signed [COORD_W-1:0] pt_x_r, pt_y_r;
  logic [PRES_W-1:0]         pt_p_r;
  logic                      pt_first_r, pt_last_r;

  // stroke state
  logic signed [COORD_W-1:0] prev_x_r, prev_y_r;
  logic [PRES_W-1:0]         prev_p_r;
  logic [DIST_W-1:0]         dist_left_r;
  logic [IDX_W-1:0]          count_r;
  logic signed [COORD_W-1:0] last_x_r, last_y_r;
  logic [PRES_W-1:0]         min_p_r, max_p_r;
  logic                      capped_flag_r;

  // segment work
  logic [LEN_W-1:0]  mag_x_r, mag_y_r;
  logic [PRES_W-1:0] mag_p_r;
  logic              neg_x_r, neg_y_r, neg_p_r;
  logic [LEN_W-1:0]  len_r;
  logic [T_W-1:0]    t_r;
  logic [RAD_W-1:0]  prod_r, sum_r;
  palr_comp_t        comp_r;
  logic [MADE_W-1:0] made_r;
  logic              trunc_r;
  logic              var_r;
  logic signed [COORD_W-1:0] samp_x_r, samp_y_r;
  logic [PRES_W-1:0]         samp_p_r;
  logic [NRES_W-1:0] n_r, k_r;
  logic              out_valid_r;

  logic in_fire, out_fire;
  assign in_fire  = in_chan.valid && in_chan.ready;
  assign out_fire = out_valid_r && out_chan.ready;

  // ---------------- configuration port ----------------
  palr_reg_t cfg_sel;
  assign cfg_sel = palr_reg_t'(paddr[2]);
  assign pready  = 1'b1;

  always_comb begin
    case (cfg_sel)
      REG_SPACING:     prdata = {{(32-SPACING_W){1'b0}}, spacing_r};
      REG_MAX_SAMPLES: prdata = {{(32-MAXS_W){1'b0}}, max_samp_r};
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spacing_r  <= SPACING_RESET;
      max_samp_r <= MAXS_RESET;
    end else if (psel && penable && pwrite) begin
      case (cfg_sel)
        REG_SPACING:     spacing_r  <= pwdata[SPACING_W-1:0];
        REG_MAX_SAMPLES: max_samp_r <= pwdata[MAXS_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- shared units ----------------
  palr_unit_ctl_t   unit_ctl;
  palr_unit_sts_t   unit_sts;
  logic [RAD_W-1:0] unit_operand;

  palr_iter_unit u_iter (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (unit_ctl),
    .operand (unit_operand),
    .divisor (len_r),
    .sts     (unit_sts)
  );

  logic                ram_we;
  palr_entry_t         ram_wdata, ram_rdata;
  logic [$bits(palr_entry_t)-1:0] ram_rbits;

  palr_ram #(.WIDTH($bits(palr_entry_t)), .DEPTH(MAX_RESULTS)) u_buf (
    .clk   (clk),
    .we    (ram_we),
    .waddr (n_r[BUF_AW-1:0]),
    .wdata (ram_wdata),
    .raddr (k_r[BUF_AW-1:0]),
    .rdata (ram_rbits)
  );
  assign ram_rdata = palr_entry_t'(ram_rbits);

  logic [LEN_W-1:0] mul_a, mul_b;
  always_comb begin
    mul_a = mag_x_r;
    mul_b = mag_x_r;
    case (state_r)
      ST_SQY: begin
        mul_a = mag_y_r;
        mul_b = mag_y_r;
      end
      ST_MUL: begin
        mul_b = t_r[LEN_W-1:0];
        case (comp_r)
          COMP_X:  mul_a = mag_x_r;
          COMP_Y:  mul_a = mag_y_r;
          COMP_P:  mul_a = {{(LEN_W-PRES_W){1'b0}}, mag_p_r};
          default: mul_a = mag_x_r;
        endcase
      end
      default: ;
    endcase
  end

  // ---------------- combinational helpers ----------------
  logic signed [LEN_W-1:0] dx, dy, tx, ty;
  logic signed [PRES_W:0]  dp;
  logic [LEN_W-1:0]        ax_t, ay_t;
  logic                    tail_far;
  logic [MAXS_W-1:0]       limit;
  logic [PRES_W-1:0]       lo_t, hi_t;
  logic                    tail_emit;
  logic signed [LEN_W-1:0] lerp_base, lerp_val;
  logic                    lerp_neg;

  always_comb begin
    dx = LEN_W'(pt_x_r) - LEN_W'(prev_x_r);
    dy = LEN_W'(pt_y_r) - LEN_W'(prev_y_r);
    dp = {1'b0, pt_p_r} - {1'b0, prev_p_r};
    tx = LEN_W'(pt_x_r) - LEN_W'(last_x_r);
    ty = LEN_W'(pt_y_r) - LEN_W'(last_y_r);
    ax_t = tx[LEN_W-1] ? -tx : tx;
    ay_t = ty[LEN_W-1] ? -ty : ty;
    // squared distance >= 7: either axis at least 3, or both at 2
    tail_far = (ax_t >= LEN_W'(3)) || (ay_t >= LEN_W'(3)) ||
               ({2'b00, ax_t[1:0]} * {2'b00, ax_t[1:0]} +
                {2'b00, ay_t[1:0]} * {2'b00, ay_t[1:0]} >= TAIL_DIST2);
    tail_emit = pt_last_r && tail_far;
    limit = (max_samp_r < MAXS_W'(2)) ? MAXS_W'(1) : max_samp_r - 1'b1;

    lo_t = min_p_r;
    hi_t = max_p_r;
    if (tail_emit) begin
      if (pt_p_r < lo_t) lo_t = pt_p_r;
      if (pt_p_r > hi_t) hi_t = pt_p_r;
    end

    case (comp_r)
      COMP_X: begin
        lerp_base = LEN_W'(prev_x_r);
        lerp_neg  = neg_x_r;
      end
      COMP_Y: begin
        lerp_base = LEN_W'(prev_y_r);
        lerp_neg  = neg_y_r;
      end
      default: begin
        lerp_base = {{(LEN_W-PRES_W){1'b0}}, prev_p_r};
        lerp_neg  = neg_p_r;
      end
    endcase
    lerp_val = lerp_neg ? lerp_base - $signed(unit_sts.result)
                        : lerp_base + $signed(unit_sts.result);
  end

  // ---------------- next state ----------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:      if (in_fire) state_nxt = ST_EVAL;
      ST_EVAL:      state_nxt = pt_first_r ? ST_TAIL : ST_SQX;
      ST_SQX:       state_nxt = ST_SQY;
      ST_SQY:       state_nxt = ST_ROOT_GO;
      ST_ROOT_GO:   state_nxt = ST_ROOT_WAIT;
      ST_ROOT_WAIT: if (unit_sts.done) state_nxt = ST_LOOP;
      ST_LOOP: begin
        if (capped_flag_r || len_r == '0 || t_r > {1'b0, len_r} ||
            count_r >= limit || made_r == MADE_W'(MAX_PER_POINT)) begin
          state_nxt = ST_END_SEG;
        end else begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL:       state_nxt = ST_DIV_GO;
      ST_DIV_GO:    state_nxt = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (unit_sts.done) begin
          state_nxt = (comp_r == COMP_P) ? ST_STORE : ST_MUL;
        end
      end
      ST_STORE:     state_nxt = ST_LOOP;
      ST_END_SEG:   state_nxt = ST_TAIL;
      ST_TAIL: begin
        state_nxt = (n_r == '0 && !tail_emit) ? ST_IDLE : ST_DRAIN_RD;
      end
      ST_DRAIN_RD:  if (!out_valid_r || out_chan.ready) state_nxt = ST_DRAIN_LD;
      ST_DRAIN_LD:  state_nxt = (k_r + 1'b1 == n_r) ? ST_IDLE : ST_DRAIN_RD;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // ---------------- outputs ----------------
  always_comb begin
    in_chan.ready  = (state_r == ST_IDLE);
    unit_ctl.start = 1'b0;
    unit_ctl.op    = OP_ROOT;
    unit_operand   = sum_r + prod_r;
    ram_we         = 1'b0;
    ram_wdata      = '{x: pt_x_r, y: pt_y_r, p: pt_p_r, idx: count_r, tail: 1'b1};
    case (state_r)
      ST_EVAL: begin
        ram_we         = pt_first_r;
        ram_wdata.idx  = '0;
        ram_wdata.tail = 1'b0;
      end
      ST_ROOT_GO: unit_ctl.start = 1'b1;
      ST_DIV_GO: begin
        unit_ctl.start = 1'b1;
        unit_ctl.op    = OP_DIV;
        unit_operand   = prod_r + {{(RAD_W-LEN_W+1){1'b0}}, len_r[LEN_W-1:1]};
      end
      ST_STORE: begin
        ram_we    = 1'b1;
        ram_wdata = '{x: samp_x_r, y: samp_y_r, p: samp_p_r, idx: count_r, tail: 1'b0};
      end
      ST_TAIL: ram_we = tail_emit;
      default: ;
    endcase
  end

  assign out_chan.valid = out_valid_r;

  // ---------------- control registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      out_valid_r   <= 1'b0;
      prev_x_r      <= '0;
      prev_y_r      <= '0;
      prev_p_r      <= '0;
      dist_left_r   <= DIST_W'(SPACING_RESET);
      count_r       <= '0;
      last_x_r      <= '0;
      last_y_r      <= '0;
      min_p_r       <= '1;
      max_p_r       <= '0;
      capped_flag_r <= 1'b0;
      n_r           <= '0;
      k_r           <= '0;
      made_r        <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_DRAIN_LD) begin
        out_valid_r <= 1'b1;
      end else if (out_fire) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          n_r    <= '0;
          k_r    <= '0;
          made_r <= '0;
        end
        ST_EVAL: begin
          if (pt_first_r) begin
            dist_left_r   <= DIST_W'(spacing_r);
            capped_flag_r <= 1'b0;
            min_p_r       <= pt_p_r;
            max_p_r       <= pt_p_r;
            last_x_r      <= pt_x_r;
            last_y_r      <= pt_y_r;
            count_r       <= IDX_W'(1);
            n_r           <= NRES_W'(1);
          end
        end
        ST_LOOP: begin
          if (!capped_flag_r && len_r != '0 && t_r <= {1'b0, len_r} &&
              count_r >= limit) begin
            capped_flag_r <= 1'b1;
          end
        end
        ST_STORE: begin
          last_x_r <= samp_x_r;
          last_y_r <= samp_y_r;
          if (samp_p_r < min_p_r) min_p_r <= samp_p_r;
          if (samp_p_r > max_p_r) max_p_r <= samp_p_r;
          count_r <= count_r + 1'b1;
          made_r  <= made_r + 1'b1;
          n_r     <= n_r + 1'b1;
        end
        ST_END_SEG: begin
          if (!capped_flag_r) begin
            dist_left_r <= trunc_r ? DIST_W'(spacing_r)
                                   : DIST_W'(t_r - {1'b0, len_r});
          end
        end
        ST_TAIL: begin
          prev_x_r <= pt_x_r;
          prev_y_r <= pt_y_r;
          prev_p_r <= pt_p_r;
          if (tail_emit) n_r <= n_r + 1'b1;
        end
        ST_DRAIN_LD: k_r <= k_r + 1'b1;
        default: ;
      endcase
    end
  end

  // ---------------- datapath registers ----------------
  always_ff @(posedge clk) begin
    if (in_fire) begin
      pt_x_r     <= in_chan.x_pos;
      pt_y_r     <= in_chan.y_pos;
      pt_p_r     <= in_chan.pen_pressure;
      pt_first_r <= in_chan.first_point;
      pt_last_r  <= in_chan.last_point;
      trunc_r    <= 1'b0;
    end
    case (state_r)
      ST_EVAL: begin
        mag_x_r <= dx[LEN_W-1] ? -dx : dx;
        mag_y_r <= dy[LEN_W-1] ? -dy : dy;
        mag_p_r <= dp[PRES_W] ? PRES_W'(-dp) : dp[PRES_W-1:0];
        neg_x_r <= dx[LEN_W-1];
        neg_y_r <= dy[LEN_W-1];
        neg_p_r <= dp[PRES_W];
        t_r     <= T_W'(dist_left_r);
      end
      ST_SQX: prod_r <= mul_a * mul_b;
      ST_SQY: begin
        sum_r  <= prod_r;
        prod_r <= mul_a * mul_b;
      end
      ST_ROOT_WAIT: if (unit_sts.done) len_r <= unit_sts.result;
      ST_LOOP: begin
        comp_r <= COMP_X;
        if (!capped_flag_r && len_r != '0 && t_r <= {1'b0, len_r} &&
            count_r < limit && made_r == MADE_W'(MAX_PER_POINT)) begin
          trunc_r <= 1'b1;
        end
      end
      ST_MUL: prod_r <= mul_a * mul_b;
      ST_DIV_WAIT: begin
        if (unit_sts.done) begin
          case (comp_r)
            COMP_X: begin
              samp_x_r <= lerp_val[COORD_W-1:0];
              comp_r   <= COMP_Y;
            end
            COMP_Y: begin
              samp_y_r <= lerp_val[COORD_W-1:0];
              comp_r   <= COMP_P;
            end
            default: samp_p_r <= lerp_val[PRES_W-1:0];
          endcase
        end
      end
      ST_STORE: t_r <= t_r + T_W'(spacing_r);
      ST_TAIL:  var_r <= (hi_t >= lo_t) && (hi_t - lo_t >= VAR_THRESHOLD);
      ST_DRAIN_LD: begin
        out_chan.sample_x          <= ram_rdata.x;
        out_chan.sample_y          <= ram_rdata.y;
        out_chan.sample_pressure   <= ram_rdata.p;
        out_chan.sample_index      <= ram_rdata.idx;
        out_chan.is_tail           <= ram_rdata.tail;
        out_chan.capped            <= capped_flag_r;
        out_chan.truncated         <= trunc_r;
        out_chan.variable_pressure <= var_r;
        out_chan.run_end           <= (k_r + 1'b1 == n_r);
      end
      default: ;
    endcase
  end

  // ---------------- assertions ----------------
  a_buf_bound: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= NRES_W'(MAX_RESULTS))
    else $error("result buffer overrun");

  a_made_bound: assert property (@(posedge clk) disable iff (!rst_n)
    made_r <= MADE_W'(MAX_PER_POINT))
    else $error("per-point sample count overrun");

  a_unit_done: assert property (@(posedge clk) disable iff (!rst_n)
    unit_sts.done |-> (state_r == ST_ROOT_WAIT || state_r == ST_DIV_WAIT))
    else $error("shared unit finished outside a wait state");

  a_cap_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(capped_flag_r) |-> $past(state_r) == ST_LOOP)
    else $error("capped flag set outside the sample loop");

  a_drain_idx: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DRAIN_LD |-> k_r < n_r)
    else $error("drain read beyond buffered results");

endmodule

>>> design/palr_ram.sv
// ----------------------------------------------------------------------------
// palr_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module palr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/palr_iter_unit.sv
// ----------------------------------------------------------------------------
// palr_iter_unit: shared root / divide unit
// Digit-serial integer square root (two radicand bits a cycle) and restoring
// division (one quotient bit a cycle).
// ----------------------------------------------------------------------------
module palr_iter_unit import palr_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  palr_unit_ctl_t   ctl,
  input  logic [RAD_W-1:0] operand,
  input  logic [LEN_W-1:0] divisor,
  output palr_unit_sts_t   sts
);

  logic [RAD_W-1:0] acc_r;
  logic [LEN_W+1:0] rem_r;
  logic [LEN_W-1:0] res_r;
  logic [LEN_W-1:0] div_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  palr_op_t         op_r;

  logic [LEN_W+2:0] rem_s;
  logic [LEN_W+2:0] trial_s;
  logic             ge_s;
  logic [LEN_W:0]   rem_d;
  logic             ge_d;

  always_comb begin
    rem_s   = {rem_r[LEN_W:0], acc_r[RAD_W-1 -: 2]};
    trial_s = {1'b0, res_r, 2'b01};
    ge_s    = (rem_s >= trial_s);
    rem_d   = {rem_r[LEN_W-1:0], acc_r[RAD_W-1]};
    ge_d    = (rem_d >= {1'b0, div_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && (cnt_r == '0);
      if (ctl.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == '0) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      op_r  <= ctl.op;
      div_r <= divisor;
      cnt_r <= CNT_W'(LEN_W - 1);
      res_r <= '0;
      if (ctl.op == OP_ROOT) begin
        acc_r <= operand;
        rem_r <= '0;
      end else begin
        // high half is already below the divisor, so the quotient fits LEN_W
        acc_r <= {operand[LEN_W-1:0], {(RAD_W-LEN_W){1'b0}}};
        rem_r <= {2'b00, operand[RAD_W-1:LEN_W]};
      end
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (op_r == OP_ROOT) begin
        rem_r <= ge_s ? (LEN_W+2)'(rem_s - trial_s) : rem_s[LEN_W+1:0];
        res_r <= {res_r[LEN_W-2:0], ge_s};
        acc_r <= {acc_r[RAD_W-3:0], 2'b00};
      end else begin
        rem_r <= {1'b0, ge_d ? (rem_d - {1'b0, div_r}) : rem_d};
        res_r <= {res_r[LEN_W-2:0], ge_d};
        acc_r <= {acc_r[RAD_W-2:0], 1'b0};
      end
    end
  end

  assign sts.done   = done_r;
  assign sts.result = res_r;

endmodule

>>> tb/palr_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// palr_checker: resampler scoreboard
// Watches the point and sample channels and the register port, predicts the
// samples of every accepted point and compares them field by field in order.
// ----------------------------------------------------------------------------
module palr_checker import palr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  palr_in_if          pts,
  palr_out_if         smp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output int          fail_cnt,
  output int          pending
);

  typedef struct {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [PRES_W-1:0]  p;
    logic [IDX_W-1:0]   idx;
    logic               tail;
    logic               capped;
    logic               trunc;
    logic               varp;
    logic               run_end;
  } sample_t;

  sample_t samples_due[$];

  // register copies and stroke state
  longint unsigned spacing_r, max_samples_r;
  longint          px, py, lsx, lsy;
  longint unsigned pp, dist_left, scount, pmin, pmax;
  bit              capped_st;

  assign pending = samples_due.size();

  function automatic longint unsigned seg_root(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned absdiff(longint a, longint b);
    return (a >= b) ? longint'(a - b) : longint'(b - a);
  endfunction

  function automatic longint interp(longint a, longint b, longint unsigned t,
                                    longint unsigned len);
    longint unsigned q;
    q = (absdiff(b, a) * t + len / 2) / len;
    return (b < a) ? a - longint'(q) : a + longint'(q);
  endfunction

  task automatic resample_point(longint x, longint y, longint unsigned p,
                                bit first, bit last);
    sample_t         run[$];
    sample_t         s;
    longint unsigned lim, ax, ay, len, t, lo, hi;
    longint          sx, sy, sp;
    int              made;
    bit              trunc, stop_cap;
    trunc = 0;
    stop_cap = 0;
    made = 0;
    lim = (max_samples_r < 2) ? 1 : max_samples_r - 1;
    if (first) begin
      dist_left = spacing_r;
      capped_st = 0;
      pmin = p;
      pmax = p;
      s = '{x[COORD_W-1:0], y[COORD_W-1:0], p[PRES_W-1:0], '0,
            1'b0, 1'b0, 1'b0, 1'b0, 1'b0};
      run.push_back(s);
      lsx = x;
      lsy = y;
      scount = 1;
    end else begin
      ax = absdiff(x, px);
      ay = absdiff(y, py);
      len = seg_root(ax * ax + ay * ay);
      t = dist_left;
      if (!capped_st && len > 0) begin
        while (t <= len) begin
          if (scount >= lim) begin
            capped_st = 1;
            stop_cap = 1;
            break;
          end
          if (made >= MAX_PER_POINT) begin
            trunc = 1;
            break;
          end
          sx = interp(px, x, t, len);
          sy = interp(py, y, t, len);
          sp = interp(longint'(pp), longint'(p), t, len);
          s = '{sx[COORD_W-1:0], sy[COORD_W-1:0], sp[PRES_W-1:0], scount[IDX_W-1:0],
                1'b0, 1'b0, 1'b0, 1'b0, 1'b0};
          run.push_back(s);
          lsx = sx;
          lsy = sy;
          if (sp < pmin) pmin = sp;
          if (sp > pmax) pmax = sp;
          scount = (scount + 1) & 16'hFFFF;
          made++;
          t += spacing_r;
        end
      end
      if (!capped_st && !stop_cap)
        dist_left = trunc ? spacing_r : ((t - len) & 29'h1FFFFFFF);
    end
    px = x;
    py = y;
    pp = p;
    lo = pmin;
    hi = pmax;
    if (last) begin
      ax = absdiff(x, lsx);
      ay = absdiff(y, lsy);
      if (ax * ax + ay * ay >= TAIL_DIST2) begin
        s = '{x[COORD_W-1:0], y[COORD_W-1:0], p[PRES_W-1:0], scount[IDX_W-1:0],
              1'b1, 1'b0, 1'b0, 1'b0, 1'b0};
        run.push_back(s);
        if (p < lo) lo = p;
        if (p > hi) hi = p;
      end
    end
    foreach (run[k]) begin
      run[k].capped  = capped_st;
      run[k].trunc   = trunc;
      run[k].varp    = (hi >= lo) && (hi - lo >= VAR_THRESHOLD);
      run[k].run_end = (k == run.size() - 1);
      samples_due.push_back(run[k]);
    end
  endtask

  always @(posedge clk) begin
    sample_t e;
    if (!rst_n) begin
      spacing_r = SPACING_RESET;
      max_samples_r = MAXS_RESET;
      px = 0; py = 0; pp = 0; lsx = 0; lsy = 0;
      dist_left = SPACING_RESET;
      scount = 0;
      pmin = 65535;
      pmax = 0;
      capped_st = 0;
      samples_due.delete();
      fail_cnt = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_SPACING) spacing_r = pwdata[SPACING_W-1:0];
        else max_samples_r = pwdata[MAXS_W-1:0];
      end
      if (smp.valid && smp.ready) begin
        if (samples_due.size() == 0) begin
          $display("%0t: sample transaction with nothing expected (x=%0d y=%0d idx=%0d)",
                   $time, smp.sample_x, smp.sample_y, smp.sample_index);
          fail_cnt++;
        end else begin
          e = samples_due.pop_front();
          if ({smp.sample_x, smp.sample_y, smp.sample_pressure, smp.sample_index,
               smp.is_tail, smp.capped, smp.truncated, smp.variable_pressure,
               smp.run_end} !== {e.x, e.y, e.p, e.idx, e.tail, e.capped, e.trunc,
                                 e.varp, e.run_end}) begin
            $display("%0t: sample mismatch exp x=%0h y=%0h p=%0h idx=%0d tail=%b cap=%b trn=%b var=%b end=%b",
                     $time, e.x, e.y, e.p, e.idx, e.tail, e.capped, e.trunc, e.varp,
                     e.run_end);
            $display("%0t:                 act x=%0h y=%0h p=%0h idx=%0d tail=%b cap=%b trn=%b var=%b end=%b",
                     $time, smp.sample_x, smp.sample_y, smp.sample_pressure,
                     smp.sample_index, smp.is_tail, smp.capped, smp.truncated,
                     smp.variable_pressure, smp.run_end);
            fail_cnt++;
          end
        end
      end
      if (pts.valid && pts.ready)
        resample_point(longint'(pts.x_pos), longint'(pts.y_pos), pts.pen_pressure,
                       pts.first_point, pts.last_point);
    end
  end

endmodule

>>> tb/polyline_arc_length_resampler_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// polyline_arc_length_resampler_unit_tb: resampler regression
// Directed strokes for the corner cases, then random strokes under several
// register settings and idle/stall mixes; the checker predicts every sample.
// ----------------------------------------------------------------------------
module polyline_arc_length_resampler_unit_tb;
  import palr_pkg::*;

  localparam longint CMAX = 134217727;
  localparam longint CMIN = -134217728;
  localparam int     CYCLE_LIMIT = 20000000;

  logic        clk;
  logic        rst_n;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          fail_cnt, pending;
  int          send_idle, recv_stall, hold_left, cycles;
  bit          hold_req;
  longint      cur_spacing;
  longint      cx, cy;

  palr_in_if  in_if ();
  palr_out_if out_if ();

  polyline_arc_length_resampler_unit dut (
    .clk(clk), .rst_n(rst_n), .in_chan(in_if), .out_chan(out_if),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  palr_checker chk (
    .clk(clk), .rst_n(rst_n), .pts(in_if), .smp(out_if),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata), .fail_cnt(fail_cnt), .pending(pending)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // receiver: random stalls plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req = 0;
      hold_left = 3000;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_if.ready = 1'b0;
    end else begin
      out_if.ready = ($urandom_range(99) >= recv_stall);
    end
  end

  task automatic reg_write(palr_reg_t r, logic [31:0] v);
    @(negedge clk);
    psel = 1; penable = 0; pwrite = 1; paddr = {r, 2'b00}; pwdata = v;
    @(negedge clk);
    penable = 1;
    @(negedge clk);
    psel = 0; penable = 0; pwrite = 0;
    if (r == REG_SPACING) cur_spacing = v[SPACING_W-1:0];
  endtask

  // every sample back, then room for a point that produces none
  task automatic drain;
    @(negedge clk);
    in_if.valid = 0;
    while (pending != 0) @(negedge clk);
    repeat (300) @(negedge clk);
  endtask

  task automatic send_point(longint x, longint y, logic [15:0] p, bit f, bit l);
    while ($urandom_range(99) < send_idle) begin
      @(negedge clk);
      in_if.valid = 0;
    end
    @(negedge clk);
    in_if.x_pos = x[COORD_W-1:0];
    in_if.y_pos = y[COORD_W-1:0];
    in_if.pen_pressure = p;
    in_if.first_point = f;
    in_if.last_point = l;
    in_if.valid = 1;
    do @(posedge clk); while (!in_if.ready);
    cx = x;
    cy = y;
  endtask

  function automatic longint clamp28(longint v);
    return (v > CMAX) ? CMAX : (v < CMIN) ? CMIN : v;
  endfunction

  function automatic longint rnd_full();
    return longint'($urandom_range(CMAX)) - longint'($urandom_range(1)) * 134217728;
  endfunction

  function automatic longint rnd_step();
    longint m;
    m = longint'($urandom_range(3 * cur_spacing + 16));
    return $urandom_range(1) ? -m : m;
  endfunction

  task automatic random_strokes(int n);
    int cnt, len;
    bit l;
    cnt = 0;
    while (cnt < n) begin
      len = $urandom_range(2, 8);
      if ($urandom_range(9) != 0) begin
        if ($urandom_range(9) == 0)
          send_point(rnd_full(), rnd_full(), 16'($urandom), 1, 0);
        else send_point($signed($urandom_range(2 << 20)) - (1 << 20),
                        $signed($urandom_range(2 << 20)) - (1 << 20), 16'($urandom), 1, 0);
        cnt++;
      end
      for (int i = 1; i < len; i++) begin
        l = (i == len - 1) && ($urandom_range(6) != 0);
        case ($urandom_range(49))
          0: send_point(rnd_full(), rnd_full(), 16'($urandom), 0, l);
          1: send_point(cx, cy, 16'($urandom), 0, l);
          default: send_point(clamp28(cx + rnd_step()), clamp28(cy + rnd_step()),
                              16'($urandom), 0, l);
        endcase
        cnt++;
      end
    end
  endtask

  initial begin
    int sp_set[4];
    int ms_set[4];
    sp_set = '{128, 1280, 1048575, 0};
    ms_set = '{65535, 2, 0, 50000};
    rst_n = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    in_if.valid = 0; in_if.x_pos = '0; in_if.y_pos = '0; in_if.pen_pressure = '0;
    in_if.first_point = 0; in_if.last_point = 0;
    out_if.ready = 1;
    send_idle = 0; recv_stall = 0; hold_left = 0; hold_req = 0; cycles = 0;
    cur_spacing = 1280; cx = 0; cy = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // points with no first point continue the reset state
    send_point(600, 0, 16'hFFFF, 0, 0);
    send_point(CMAX, CMIN, 16'h0000, 1, 0);
    send_point(CMIN, CMAX, 16'hFFFF, 0, 1);     // long segment: truncation
    send_point(5, 5, 100, 1, 1);                 // first and last together
    send_point(0, 0, 0, 1, 0);
    send_point(0, 0, 5, 0, 0);                   // zero length segment
    send_point(2000, -1300, 60000, 0, 0);
    send_point(2002, -1301, 60000, 0, 1);        // tail close to the previous point
    send_point(-3000, 40, 700, 1, 0);
    send_point(-3000, 4000, 0, 0, 1);            // tail far, variable pressure
    drain();
    reg_write(REG_SPACING, 0);                   // zero spacing repeats a place
    reg_write(REG_MAX_SAMPLES, 0);               // acts as two
    send_point(0, 0, 1, 1, 0);
    send_point(900, 900, 2, 0, 0);
    send_point(1900, 900, 2, 0, 1);
    drain();
    reg_write(REG_MAX_SAMPLES, 65535);
    reg_write(REG_SPACING, 128);
    send_point(0, 0, 300, 1, 0);
    send_point(1000, 0, 900, 0, 0);
    send_point(1000, -1000, 200, 0, 1);
    drain();

    // long receiver hold-off while points are waiting: the input stalls
    reg_write(REG_SPACING, 1280);
    hold_req = 1;
    send_point(0, 0, 1000, 1, 0);
    for (int i = 1; i <= 6; i++)
      send_point(i * 25600, 0, 16'(1000 + i * 10), 0, i == 6);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      reg_write(REG_SPACING, (ph == 3) ? $urandom_range(128, 5000) : sp_set[ph]);
      reg_write(REG_MAX_SAMPLES, (ph == 2) ? $urandom_range(3, 40) : ms_set[ph]);
      case (ph)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 86; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 86; end
        default: begin send_idle = 27; recv_stall = 27; end
      endcase
      random_strokes(80);
      drain();
    end
    send_idle = 0;
    recv_stall = 0;
    drain();

    if (fail_cnt == 0 && pending == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

>>> polyline_arc_length_resampler_unit.f
design/palr_pkg.sv
design/palr_in_if.sv
design/palr_out_if.sv
design/palr_ram.sv
design/palr_iter_unit.sv
design/polyline_arc_length_resampler_unit.sv
tb/palr_checker.sv
tb/polyline_arc_length_resampler_unit_tb.sv
